// ===== rtl/mt19937_bounded_random_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked, reset-qualified property helpers.
// ----------------------------------------------------------------------------
`ifndef MT19937_BOUNDED_RANDOM_CORE_DEFINES_SVH
`define MT19937_BOUNDED_RANDOM_CORE_DEFINES_SVH

// implication checked on every clock outside reset
`define MTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/mtb_pkg.sv =====
// ----------------------------------------------------------------------------
// mtb_pkg
// Types, constants and helpers for the bounded MT19937 core.
// ----------------------------------------------------------------------------
package mtb_pkg;
	localparam int StateWords  = 624;
	localparam int TwistOffset = 397;

	localparam logic [31:0] InitMult  = 32'd1812433253;
	localparam logic [31:0] InitSeed  = 32'd19650218;
	localparam logic [31:0] MixMultA  = 32'd1664525;
	localparam logic [31:0] MixMultB  = 32'd1566083941;
	localparam logic [31:0] UpperMask = 32'h80000000;
	localparam logic [31:0] MatrixA   = 32'h9908b0df;
	localparam logic [31:0] TemperB   = 32'h9d2c5680;
	localparam logic [31:0] TemperC   = 32'hefc60000;

	localparam logic [1:0] ModeTop    = 2'd0;
	localparam logic [1:0] ModeBelow  = 2'd1;
	localparam logic [1:0] ModeRange  = 2'd2;
	localparam logic [1:0] ModeUnused = 2'd3;

	localparam logic [0:0] RegSeed = 1'b0;

	typedef enum logic [4:0] {
		ST_LIN_RD, ST_LIN_MUL, ST_LIN_WR,
		ST_MA_RD, ST_MA_MUL, ST_MA_WR,
		ST_MB_RD, ST_MB_MUL, ST_MB_WR,
		ST_FIN,
		ST_IDLE, ST_SETUP, ST_DRAW, ST_TW_RD0, ST_TW_RD1, ST_TW_RD2,
		ST_TW_WR, ST_GET_RD, ST_GET_WAIT, ST_CHECK, ST_OUT
	} state_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [5:0] bit_len(input logic [31:0] n);
		logic [5:0] k;
		k = '0;
		for (int i = 0; i < 32; i++) begin
			if (n[i]) begin
				k = 6'(i + 1);
			end
		end
		return k;
	endfunction
endpackage

// ===== rtl/mtb_if.sv =====
// ----------------------------------------------------------------------------
// mtb_req_if / mtb_rsp_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface mtb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [5:0]  bits_wanted;
	logic [31:0] bound;
	logic signed [31:0] low_end;
	logic signed [31:0] high_end;
	modport source (output valid, mode, bits_wanted, bound, low_end, high_end, input ready);
	modport sink (input valid, mode, bits_wanted, bound, low_end, high_end, output ready);
endinterface

interface mtb_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [32:0] value;
	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface

// ===== rtl/mt19937_bounded_random_core.sv =====
// ----------------------------------------------------------------------------
// mt19937_bounded_random_core
// MT19937 with CPython-style seeding and bounded draws.
// ----------------------------------------------------------------------------
// After reset and after every seed write, the core rebuilds its 624-word
// state in a memory with one read and one write port, using one shared
// registered multiplier: a start state, a multiply and a write per word for
// the 623-word linear fill, a read, a multiply and a write per word for the
// 624-word and 623-word mixing passes, and one final write; meanwhile no
// request word is taken (config writes are still taken). A request goes from
// its accept through a setup state, then per drawn word through draw, three
// twist reads, twist write, read, wait and check, then to an output state
// that raises the result; requests that draw nothing go from setup straight
// to the result. The state is twisted lazily one word at a time, so word i
// is twisted right before its first use, since its inputs (i+1, i+397) are
// still old values except i+397 wrapped, which was already twisted as
// required. Mode 1 and 2 rejection redraws repeat the draw loop. The single
// memory read port makes the twist and draw reads take turns.
module mt19937_bounded_random_core #(
	parameter int STATE_WORDS  = mtb_pkg::StateWords,
	parameter int TWIST_OFFSET = mtb_pkg::TwistOffset
) (
	input  logic        clk,
	input  logic        arst_n,
	mtb_req_if.sink     req,
	mtb_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import mtb_pkg::*;
	`include "mt19937_bounded_random_core_defines.svh"

	localparam int IW = $clog2(STATE_WORDS + 1);

	logic [31:0] mem [STATE_WORDS];
	logic [31:0] rd_q;
	logic [IW-1:0] raddr, waddr;
	logic          we;
	logic [31:0]   wdata;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[IW-1:0]] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	state_t st_q, st_d;
	logic [63:0] seed_q;
	logic        cfg_wr;
	logic [IW-1:0] i_q, k_q, idx_q;
	logic [31:0] prev_q, cur_q, cur2_q;
	logic        j_q;
	logic        twisted_q;   // a twist pass is in progress (lazy)
	logic [1:0]  mode_q;
	logic [5:0]  k_bits_q;
	logic [31:0] n_q, base_q, draw_q;
	logic [31:0] out_q;
	logic        out_v_q;
	logic [31:0] ma, mb, mp;

	assign cfg_wr = psel && penable && pwrite && (paddr == RegSeed);
	assign pready = 1'b1;
	assign prdata = seed_q;

	mtb_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	logic [31:0] key_w, px, span, tw_y, tw_new, tv, top_v;
	logic [IW-1:0] nx_idx, far_idx;
	logic [5:0] sh;
	always_comb begin
		key_w  = j_q ? seed_q[63:32] : seed_q[31:0];
		px     = prev_q ^ (prev_q >> 30);
		ma     = px;
		mb     = (st_q == ST_LIN_MUL) ? InitMult
			: ((st_q == ST_MA_MUL) ? MixMultA : MixMultB);
		nx_idx = (idx_q == IW'(STATE_WORDS - 1)) ? '0 : idx_q + IW'(1);
		far_idx = (idx_q >= IW'(STATE_WORDS - TWIST_OFFSET))
			? idx_q - IW'(STATE_WORDS - TWIST_OFFSET) : idx_q + IW'(TWIST_OFFSET);
		tw_y   = (cur_q & UpperMask) | (cur2_q & ~UpperMask);
		tw_new = rd_q ^ (tw_y >> 1) ^ (tw_y[0] ? MatrixA : 32'd0);
		tv     = temper(draw_q);
		sh     = 6'd32 - k_bits_q;
		top_v  = (k_bits_q == 6'd0) ? 32'd0 : ((k_bits_q >= 6'd32) ? tv : (tv >> sh[4:0]));
		span   = 32'(req.high_end) - 32'(req.low_end) + 32'd1;
	end

	always_comb begin
		st_d  = st_q;
		raddr = i_q;
		we    = 1'b0;
		waddr = i_q;
		wdata = mp;
		unique case (st_q)
			ST_LIN_RD:  st_d = ST_LIN_MUL;
			ST_LIN_MUL: st_d = ST_LIN_WR;
			ST_LIN_WR: begin
				we = 1'b1; wdata = mp + 32'(i_q);
				st_d = (i_q == IW'(STATE_WORDS - 1)) ? ST_MA_RD : ST_LIN_MUL;
			end
			ST_MA_RD:  st_d = ST_MA_MUL;
			ST_MA_MUL: st_d = ST_MA_WR;
			ST_MA_WR: begin
				we = 1'b1; wdata = (rd_q ^ mp) + key_w + 32'(j_q);
				if (i_q == IW'(STATE_WORDS - 1)) begin
					waddr = i_q;
				end
				st_d = (k_q == IW'(1)) ? ST_MB_RD : ST_MA_RD;
			end
			ST_MB_RD:  st_d = ST_MB_MUL;
			ST_MB_MUL: st_d = ST_MB_WR;
			ST_MB_WR: begin
				we = 1'b1; wdata = (rd_q ^ mp) - 32'(i_q);
				st_d = (k_q == IW'(1)) ? ST_FIN : ST_MB_RD;
			end
			ST_FIN: begin
				we = 1'b1; waddr = '0; wdata = UpperMask; st_d = ST_IDLE;
			end
			ST_IDLE:  st_d = (req.valid && !out_v_q) ? ST_SETUP : ST_IDLE;
			ST_SETUP: st_d = (n_q == 32'd0 && mode_q != ModeTop) ? ST_OUT
				: ((mode_q == ModeUnused) ? ST_OUT : ST_DRAW);
			ST_DRAW: begin
				raddr = (idx_q == IW'(STATE_WORDS)) ? '0 : idx_q;
				st_d = twisted_q || idx_q == IW'(STATE_WORDS) ? ST_TW_RD0 : ST_GET_RD;
				if (idx_q != IW'(STATE_WORDS) && !twisted_q) begin
					st_d = ST_GET_RD;
				end
			end
			ST_TW_RD0: begin raddr = idx_q; st_d = ST_TW_RD1; end
			ST_TW_RD1: begin raddr = nx_idx; st_d = ST_TW_RD2; end
			ST_TW_RD2: begin raddr = far_idx; st_d = ST_TW_WR; end
			ST_TW_WR: begin
				we = 1'b1; waddr = idx_q; wdata = tw_new; st_d = ST_GET_RD;
			end
			ST_GET_RD: begin raddr = idx_q; st_d = ST_GET_WAIT; end
			ST_GET_WAIT: st_d = ST_CHECK;
			ST_CHECK: st_d = (mode_q == ModeTop || top_v < n_q) ? ST_OUT : ST_DRAW;
			ST_OUT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
		if (st_q == ST_MA_WR || st_q == ST_MB_WR) begin
			waddr = i_q;
		end
	end

	// word 0 is only ever read through i-1, so prev_q stands in for it
	// across seeding wraps; the final pass write fixes its stored value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LIN_RD; seed_q <= '0; i_q <= '0; k_q <= '0; j_q <= 1'b0;
			idx_q <= IW'(STATE_WORDS); twisted_q <= 1'b0; out_v_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				seed_q <= pwdata;
			end
			if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			st_q <= cfg_wr ? ST_LIN_RD : st_d;
			if (cfg_wr) begin
				i_q <= '0; j_q <= 1'b0; idx_q <= IW'(STATE_WORDS); twisted_q <= 1'b0;
			end else begin
				unique case (st_q)
					ST_LIN_RD: begin prev_q <= InitSeed; i_q <= IW'(1); end
					ST_LIN_WR: begin
						if (i_q == IW'(STATE_WORDS - 1)) begin
							// first mixing step reads word 0 of the linear fill
							prev_q <= InitSeed;
							i_q <= IW'(1); k_q <= IW'(STATE_WORDS); j_q <= 1'b0;
						end else begin
							prev_q <= wdata;
							i_q <= i_q + IW'(1);
						end
					end
					ST_MA_WR, ST_MB_WR: begin
						prev_q <= wdata;
						if (i_q == IW'(STATE_WORDS - 1)) begin
							i_q <= IW'(1);
						end else begin
							i_q <= i_q + IW'(1);
						end
						if (st_q == ST_MA_WR && k_q == IW'(1)) begin
							k_q <= IW'(STATE_WORDS - 1);
						end else begin
							k_q <= k_q - IW'(1);
						end
						if (st_q == ST_MA_WR) begin
							j_q <= (seed_q[63:32] != 32'd0) ? ~j_q : 1'b0;
						end
					end
					ST_IDLE: begin
						if (req.valid && !out_v_q) begin
							mode_q <= req.mode;
							if (req.mode == ModeBelow) begin
								n_q <= req.bound; base_q <= '0;
								k_bits_q <= bit_len(req.bound);
							end else if (req.mode == ModeRange) begin
								n_q <= span; base_q <= 32'(req.low_end);
								k_bits_q <= bit_len(span);
							end else begin
								n_q <= 32'd1; base_q <= '0;
								k_bits_q <= (req.bits_wanted > 6'd32) ? 6'd32
									: req.bits_wanted;
							end
						end
					end
					ST_DRAW: begin
						if (idx_q == IW'(STATE_WORDS)) begin
							idx_q <= '0; twisted_q <= 1'b1;
						end
					end
					ST_TW_RD1: cur_q <= rd_q;
					ST_TW_RD2: cur2_q <= rd_q;
					ST_GET_WAIT: draw_q <= rd_q;
					ST_CHECK: begin
						idx_q <= idx_q + IW'(1);
						if (idx_q == IW'(STATE_WORDS - 1)) begin
							twisted_q <= 1'b0;
						end
						if (st_d == ST_OUT) begin
							out_q <= (mode_q == ModeTop) ? top_v : base_q + top_v;
						end
					end
					ST_SETUP: begin
						if (st_d == ST_OUT) begin
							out_q <= (mode_q == ModeRange) ? base_q : 32'd0;
						end
					end
					ST_OUT: out_v_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// sign-extend mode 2 results, zero-extend the others
	assign rsp.value = (mode_q == ModeRange) ? {out_q[31], out_q} : {1'b0, out_q};
	assign rsp.valid = out_v_q;
	assign req.ready = (st_q == ST_IDLE) && !out_v_q;

	`MTB_ASSERT_IMP(a_no_accept_busy, clk, arst_n, req.valid && req.ready, st_q == ST_IDLE)
	`MTB_ASSERT_NXT(a_out_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid)
	`MTB_ASSERT_IMP(a_idx_range, clk, arst_n, 1'b1, idx_q <= IW'(STATE_WORDS))
endmodule

// ===== rtl/mtb_mul.sv =====
// ----------------------------------------------------------------------------
// mtb_mul
// Shared registered 32x32 multiplier, low product word.
// ----------------------------------------------------------------------------
module mtb_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	logic [31:0] full;
	always_comb begin
		full = a * b;
	end
	always_ff @(posedge clk) begin
		p <= full;
	end
endmodule

// ===== tb/sv/mt19937_bounded_random_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mt19937_bounded_random_core_tb
// Self-checking bench for the bounded MT19937 core. Request words go in with
// random gaps and results come out under random back-pressure, outside calm
// phases. A behavioral twister, seeded the same way, predicts every result
// value. The seed register is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module mt19937_bounded_random_core_tb;
	import mtb_pkg::*;

	localparam int IdleLimit = 40000;

	typedef struct {
		logic [1:0]         mode;
		logic [5:0]         bits_wanted;
		logic [31:0]        bound;
		logic signed [31:0] low_end;
		logic signed [31:0] high_end;
	} draw_req_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	mtb_req_if req ();
	mtb_rsp_if rsp ();

	mt19937_bounded_random_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req.sink),
		.rsp     (rsp.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// pending request words and predicted result values
	draw_req_t          pending_reqs[$];
	logic signed [32:0] expected_values[$];
	int                 error_count = 0;
	int                 idle_cycles = 0;
	bit                 calm_phase  = 0;

	// behavioral twister state
	logic [31:0] mt_words[StateWords];
	int          mt_pos;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	function automatic logic [31:0] mix30(input logic [31:0] p, input logic [31:0] m);
		logic [31:0] r;
		r = (p ^ (p >> 30)) * m;
		return r;
	endfunction

	// CPython init_by_array with a one- or two-word key
	function automatic void reseed_twister(input logic [63:0] s);
		logic [31:0] key[2];
		int          key_len;
		int          i;
		int          j;
		key[0]  = s[31:0];
		key[1]  = s[63:32];
		key_len = (key[1] != 0) ? 2 : 1;
		mt_words[0] = InitSeed;
		for (int n = 1; n < StateWords; n++) begin
			mt_words[n] = mix30(mt_words[n-1], InitMult) + 32'(n);
		end
		i = 1;
		j = 0;
		for (int k = StateWords; k > 0; k--) begin
			mt_words[i] = (mt_words[i] ^ mix30(mt_words[i-1], MixMultA)) + key[j] + 32'(j);
			i++;
			j++;
			if (i >= StateWords) begin
				mt_words[0] = mt_words[StateWords-1];
				i = 1;
			end
			if (j >= key_len) begin
				j = 0;
			end
		end
		for (int k = StateWords - 1; k > 0; k--) begin
			mt_words[i] = (mt_words[i] ^ mix30(mt_words[i-1], MixMultB)) - 32'(i);
			i++;
			if (i >= StateWords) begin
				mt_words[0] = mt_words[StateWords-1];
				i = 1;
			end
		end
		mt_words[0] = UpperMask;
		mt_pos = StateWords;
	endfunction

	function automatic logic [31:0] draw_word();
		logic [31:0] y;
		if (mt_pos >= StateWords) begin
			for (int kk = 0; kk < StateWords; kk++) begin
				y = (mt_words[kk] & UpperMask)
					| (mt_words[(kk + 1) % StateWords] & ~UpperMask);
				mt_words[kk] = mt_words[(kk + TwistOffset) % StateWords] ^ (y >> 1)
					^ (y[0] ? MatrixA : 32'h0);
			end
			mt_pos = 0;
		end
		y = mt_words[mt_pos];
		mt_pos++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] draw_top(input int k);
		logic [31:0] w;
		w = draw_word();
		if (k == 0) begin
			return 32'h0;
		end
		if (k >= 32) begin
			return w;
		end
		return w >> (32 - k);
	endfunction

	// rejection sampling below n; a zero bound draws nothing
	function automatic logic [31:0] draw_below(input logic [31:0] n);
		int          width;
		logic [31:0] r;
		width = 0;
		if (n == 0) begin
			return 32'h0;
		end
		for (int b = 0; b < 32; b++) begin
			if (n[b]) begin
				width = b + 1;
			end
		end
		r = draw_top(width);
		while (r >= n) begin
			r = draw_top(width);
		end
		return r;
	endfunction

	function automatic logic signed [32:0] predict_value(input draw_req_t d);
		logic [31:0] r;
		case (d.mode)
			ModeTop: begin
				return {1'b0, draw_top(int'(d.bits_wanted))};
			end
			ModeBelow: begin
				return {1'b0, draw_below(d.bound)};
			end
			ModeRange: begin
				r = d.low_end + draw_below(d.high_end - d.low_end + 32'd1);
				return {r[31], r};
			end
			default: begin
				return 33'sd0;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// ------------------------------------------------------------------------
	// request driver: hold a word until taken, then idle a random gap
	// ------------------------------------------------------------------------
	int  req_gap = 0;
	bit  req_taken;

	always @(negedge clk) begin
		if (arst_n) begin
			if (req.valid && !req_taken) begin
				// hold
			end else if (req_gap > 0) begin
				req_gap   <= req_gap - 1;
				req.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				draw_req_t d;
				d = pending_reqs.pop_front();
				req.mode        <= d.mode;
				req.bits_wanted <= d.bits_wanted;
				req.bound       <= d.bound;
				req.low_end     <= d.low_end;
				req.high_end    <= d.high_end;
				req.valid       <= 1'b1;
				req_gap         <= calm_phase ? 0 : $urandom_range(0, 18);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// result sink: stall a random number of cycles after each word
	int rsp_wait = 0;
	bit rsp_taken;

	always @(negedge clk) begin
		int w;
		if (arst_n) begin
			w = rsp_taken ? (calm_phase ? 0 : $urandom_range(0, 18)) : rsp_wait;
			if (w > 0) begin
				rsp_wait  <= w - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp_wait  <= 0;
				rsp.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: predict on request accept, check on result accept
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		draw_req_t          d;
		logic signed [32:0] want;
		req_taken = 1'b0;
		rsp_taken = 1'b0;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == RegSeed) begin
				reseed_twister(pwdata);
			end
			if (req.valid && req.ready) begin
				req_taken     = 1'b1;
				d.mode        = req.mode;
				d.bits_wanted = req.bits_wanted;
				d.bound       = req.bound;
				d.low_end     = req.low_end;
				d.high_end    = req.high_end;
				expected_values.push_back(predict_value(d));
			end
			if (rsp.valid && rsp.ready) begin
				rsp_taken = 1'b1;
				if (expected_values.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result word, expected none, actual %0d",
						$realtime, rsp.value);
				end else begin
					want = expected_values.pop_front();
					if (rsp.value !== want) begin
						error_count++;
						$display("%0t: value mismatch, expected %0d, actual %0d",
							$realtime, want, rsp.value);
					end
				end
			end
			// watchdog on acceptance-free stretches (reseeding included)
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IdleLimit) begin
				$display("mt19937_bounded_random_core verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic queue_req(input logic [1:0] mode, input logic [5:0] bits,
		input logic [31:0] bound, input logic [31:0] lo, input logic [31:0] hi);
		draw_req_t d;
		d.mode        = mode;
		d.bits_wanted = bits;
		d.bound       = bound;
		d.low_end     = lo;
		d.high_end    = hi;
		pending_reqs.push_back(d);
	endtask

	task automatic queue_random(input int count);
		logic [31:0] lo;
		logic [31:0] bound;
		int          pick;
		for (int n = 0; n < count; n++) begin
			lo   = $urandom;
			pick = $urandom_range(0, 3);
			case (pick)
				0: bound = $urandom;
				1: bound = $urandom_range(0, 40);
				2: bound = (32'h1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
				default: bound = $urandom >> $urandom_range(0, 31);
			endcase
			case ($urandom_range(0, 2))
				0: queue_req(ModeTop, 6'($urandom_range(1, 32)), $urandom, $urandom, $urandom);
				1: queue_req(ModeBelow, 6'($urandom), bound, $urandom, $urandom);
				default: begin
					if (pick == 0) begin
						queue_req(ModeRange, 6'($urandom), $urandom, lo, $urandom);
					end else begin
						queue_req(ModeRange, 6'($urandom), $urandom, lo, lo + bound);
					end
				end
			endcase
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || req.valid || expected_values.size() > 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
	endtask

	// register write in a setup phase, then an access phase
	task automatic write_seed(input logic [63:0] s);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= RegSeed;
		pwdata  <= s;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [63:0] seeds[5];
		psel      = 0;
		penable   = 0;
		pwrite    = 0;
		paddr     = '0;
		pwdata    = '0;
		pready    = 1'b1;
		req.valid = 0;
		req.mode  = ModeTop;
		req.bits_wanted = '0;
		req.bound    = '0;
		req.low_end  = '0;
		req.high_end = '0;
		rsp.ready = 0;
		reseed_twister(64'h0);

		seeds[0] = 64'hffff_ffff_ffff_ffff;
		seeds[1] = 64'h1;
		seeds[2] = {32'h0, $urandom};
		seeds[3] = {$urandom, $urandom};
		seeds[4] = 64'h0;

		// directed: field extremes and corner cases
		queue_req(ModeTop, 6'd1, '0, '0, '0);
		queue_req(ModeTop, 6'd32, '0, '0, '0);
		queue_req(ModeTop, 6'd0, '0, '0, '0);           // no bits wanted
		queue_req(ModeTop, 6'd63, '0, '0, '0);          // saturates to a full word
		queue_req(ModeBelow, '0, 32'd0, '0, '0);        // zero bound
		queue_req(ModeBelow, '0, 32'd1, '0, '0);
		queue_req(ModeBelow, '0, 32'd3, '0, '0);
		queue_req(ModeBelow, '0, 32'h8000_0001, '0, '0);
		queue_req(ModeBelow, '0, 32'hffff_ffff, '0, '0);
		queue_req(ModeRange, '0, '0, 32'h8000_0000, 32'h7fff_ffff);  // full range
		queue_req(ModeRange, '0, '0, 32'h7fff_ffff, 32'h8000_0000);  // reversed
		queue_req(ModeRange, '0, '0, 32'h8000_0000, 32'h8000_0000);
		queue_req(ModeRange, '0, '0, 32'h7fff_ffff, 32'h7fff_ffff);
		queue_req(ModeRange, '0, '0, -32'sd10, 32'sd10);
		queue_req(ModeRange, '0, '0, 32'sd5, -32'sd5);
		queue_req(ModeUnused, 6'h3f, 32'hffff_ffff, '1, '1);   // unused mode
		queue_random(170);
		drain();

		foreach (seeds[s]) begin
			calm_phase = (s % 2) == 1;
			write_seed(seeds[s]);
			queue_random(170);
			drain();
		end

		if (error_count == 0) begin
			$display("mt19937_bounded_random_core verification clean");
		end else begin
			$display("mt19937_bounded_random_core verification failed");
		end
		$finish;
	end
endmodule
